[sv/drbg_pkg.sv]
package drbg_pkg;

    typedef struct packed {
        logic        op;
        logic [63:0] seed_word;
        logic [63:0] pers_word;
        logic [2:0]  chunk_index;
        logic        final_block;
        logic [4:0]  want_bytes;
    } req_t;

    typedef struct packed {
        logic [63:0] data_word;
        logic        half;
        logic [3:0]  valid_bytes;
        logic        last;
    } rsp_t;

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_GEN  = 1'b1;

    typedef enum logic [1:0] {
        CMD_SEED = 2'd0,
        CMD_INST = 2'd1,
        CMD_GEN  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [2:0]  idx;
        logic [63:0] chunk;
        logic        fin;
        logic [3:0]  v0;
        logic [3:0]  v1;
    } cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // a round, no key add, mix only if mix; byte 0 in the top bits
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) b[i] = s[127 - 8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
                t[j + 4*c] = SBOX[b[j + 4*((c + j) % 4)]];
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
        return r;
    endfunction

endpackage

[sv/drbg_front.sv]
module drbg_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  drbg_pkg::req_t   in_data,
    output logic             q_valid,
    input  logic             q_stall,
    output drbg_pkg::cmd_t   q_data
);

    localparam int DEPTH = 2;

    drbg_pkg::cmd_t    mem_reg [DEPTH];
    logic              wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]        cnt_reg, cnt_next;
    drbg_pkg::cmd_t    cls;
    logic              push, pop;
    logic [4:0]        w;

    always_comb
    begin
        w = (in_data.want_bytes > 5'd16) ? 5'd16 : in_data.want_bytes;
        cls.idx = in_data.chunk_index;
        cls.chunk = in_data.seed_word ^ in_data.pers_word;
        cls.fin = in_data.final_block;
        cls.v0 = (w > 5'd8) ? 4'd8 : w[3:0];
        cls.v1 = (w > 5'd8) ? 4'(w - 5'd8) : 4'd0;
        if (in_data.op == drbg_pkg::OP_GEN)
            cls.kind = drbg_pkg::CMD_GEN;
        else if (in_data.chunk_index == 3'd5)
            cls.kind = drbg_pkg::CMD_INST;
        else
            cls.kind = drbg_pkg::CMD_SEED;
    end

    // seed chunk indexes beyond five are dropped here
    assign in_stall = (cnt_reg == 2'(DEPTH));
    assign push = in_valid && !in_stall &&
                  !(in_data.op == drbg_pkg::OP_SEED && in_data.chunk_index > 3'd5);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = mem_reg[rp_reg];
    assign pop = q_valid && !q_stall;

    always_comb
    begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= cls;
    end

endmodule

[sv/drbg_back.sv]
module drbg_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_stall,
    input  drbg_pkg::cmd_t   q_data,
    output logic             out_valid,
    input  logic             out_stall,
    output drbg_pkg::rsp_t   out_data,
    output logic             busy
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_OUT  = 4'b0100,
        S_UPD  = 4'b1000
    } state_t;

    state_t         st_reg, st_next;
    logic [255:0]   key_reg, key_next;
    logic [127:0]   ctr_reg, ctr_next;
    logic [63:0]    seed_reg [6];
    logic [255:0]   rk_reg, rk_next;     // sliding two round keys
    logic [127:0]   s_reg, s_next;
    logic [3:0]     rnd_reg, rnd_next;
    logic [2:0]     rc_reg, rc_next;
    logic [1:0]     blk_reg, blk_next;
    logic [255:0]   acc_reg, acc_next;
    logic           inst_reg, inst_next;
    logic           fin_reg, fin_next;
    logic [3:0]     v0_reg, v0_next, v1_reg, v1_next;
    logic [3:0]     ob0_reg, ob0_next, ob1_reg, ob1_next;
    logic [127:0]   res_reg, res_next;
    logic           hf_reg, hf_next;
    logic           ov_reg, ov_next;
    logic [127:0]   ctr_inc, rd;
    logic [31:0]    t, nk [4];
    logic           odd;
    logic [383:0]   upd;
    logic [383:0]   sd;
    logic           take;

    assign ctr_inc = ctr_reg + 128'd1;
    assign sd = {seed_reg[0], seed_reg[1], seed_reg[2], seed_reg[3], seed_reg[4], seed_reg[5]};
    // odd rounds build the next even round key with rotation and rcon
    assign odd = rnd_reg[0];
    assign rd = drbg_pkg::aes_round(s_reg, rnd_reg != 4'd14);

    always_comb
    begin
        t = odd ? (drbg_pkg::sub_word({rk_reg[23:0], rk_reg[31:24]})
                   ^ {8'h01 << (rc_reg - 3'd1), 24'd0})
                : drbg_pkg::sub_word(rk_reg[31:0]);
        nk[0] = rk_reg[255:224] ^ t;
        nk[1] = rk_reg[223:192] ^ nk[0];
        nk[2] = rk_reg[191:160] ^ nk[1];
        nk[3] = rk_reg[159:128] ^ nk[2];
    end

    assign take = q_valid && !q_stall;
    assign q_stall = (st_reg != S_IDLE);
    assign busy = (st_reg != S_IDLE) || ov_reg;

    always_comb
    begin
        st_next = st_reg; key_next = key_reg; ctr_next = ctr_reg;
        rk_next = rk_reg; s_next = s_reg; rnd_next = rnd_reg; rc_next = rc_reg;
        blk_next = blk_reg; acc_next = acc_reg; inst_next = inst_reg; fin_next = fin_reg;
        v0_next = v0_reg; v1_next = v1_reg; res_next = res_reg;
        ob0_next = ob0_reg; ob1_next = ob1_reg;
        hf_next = hf_reg; ov_next = ov_reg;
        upd = '0;
        if (ov_reg && !out_stall)
        begin
            if (hf_reg) ov_next = 1'b0;
            hf_next = ~hf_reg;
        end
        case (st_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    fin_next = q_data.fin; v0_next = q_data.v0; v1_next = q_data.v1;
                    case (q_data.kind)
                        drbg_pkg::CMD_SEED: ;
                        drbg_pkg::CMD_INST:
                        begin
                            inst_next = 1'b1; blk_next = 2'd0;
                            ctr_next = 128'd1;
                            rk_next = '0; rc_next = 3'd1; rnd_next = 4'd1;
                            s_next = 128'd1;
                            st_next = S_RUN;
                        end
                        drbg_pkg::CMD_GEN:
                        begin
                            inst_next = 1'b0; blk_next = 2'd3;
                            ctr_next = ctr_inc;
                            rk_next = key_reg; rc_next = 3'd1; rnd_next = 4'd1;
                            s_next = ctr_inc ^ key_reg[255:128];
                            st_next = S_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN:
            begin
                s_next = rd ^ rk_reg[127:0];
                rnd_next = rnd_reg + 4'd1;
                rk_next = {rk_reg[127:0], nk[0], nk[1], nk[2], nk[3]};
                if (!odd) rc_next = rc_reg + 3'd1;
                if (rnd_reg == 4'd14)
                begin
                    if (blk_reg == 2'd3)
                        st_next = S_OUT;
                    else
                    begin
                        if (blk_reg != 2'd2)
                            acc_next = {acc_reg[127:0], rd ^ rk_reg[127:0]};
                        st_next = S_UPD;
                    end
                end
            end
            S_OUT:
            begin
                if (!ov_reg)
                begin
                    res_next = s_reg; ov_next = 1'b1; hf_next = 1'b0;
                    ob0_next = v0_reg; ob1_next = v1_reg;
                    if (fin_reg)
                    begin
                        inst_next = 1'b0; blk_next = 2'd0;
                        ctr_next = ctr_inc;
                        rk_next = key_reg; rc_next = 3'd1; rnd_next = 4'd1;
                        s_next = ctr_inc ^ key_reg[255:128];
                        st_next = S_RUN;
                    end
                    else
                        st_next = S_IDLE;
                end
            end
            S_UPD:
            begin
                if (blk_reg == 2'd2)
                begin
                    upd = {acc_reg, s_reg} ^ (inst_reg ? sd : 384'd0);
                    key_next = upd[383:128];
                    ctr_next = upd[127:0];
                    st_next = S_IDLE;
                end
                else
                begin
                    blk_next = blk_reg + 2'd1;
                    ctr_next = ctr_inc;
                    rk_next = inst_reg ? 256'd0 : key_reg;
                    rc_next = 3'd1; rnd_next = 4'd1;
                    s_next = ctr_inc ^ (inst_reg ? 128'd0 : key_reg[255:128]);
                    st_next = S_RUN;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            key_reg <= '0;
            ctr_reg <= '0;
            ov_reg <= 1'b0;
            hf_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            key_reg <= key_next;
            ctr_reg <= ctr_next;
            ov_reg <= ov_next;
            hf_reg <= hf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rk_reg <= rk_next; s_reg <= s_next; rnd_reg <= rnd_next; rc_reg <= rc_next;
        blk_reg <= blk_next; acc_reg <= acc_next; inst_reg <= inst_next;
        fin_reg <= fin_next; v0_reg <= v0_next; v1_reg <= v1_next; res_reg <= res_next;
        ob0_reg <= ob0_next; ob1_reg <= ob1_next;
        if (take && q_data.kind != drbg_pkg::CMD_GEN)
            seed_reg[q_data.idx] <= q_data.chunk;
    end

    always_comb
    begin
        out_valid = ov_reg;
        out_data.data_word = hf_reg ? res_reg[63:0] : res_reg[127:64];
        out_data.half = hf_reg;
        out_data.valid_bytes = hf_reg ? ob1_reg : ob0_reg;
        out_data.last = hf_reg;
    end

endmodule

[sv/aes256_ctr_drbg.sv]
// generate: one AES round per cycle, 14 rounds per block, then S_OUT shows the block
// final block adds three more block encryptions for the update
// seed chunks are stored in the idle state; the last chunk runs a three-block update
// blocks share one round unit; a new command is taken only in the idle state
// rst_n clears key, counter and queue asynchronously; seed chunks are not reset
module aes256_ctr_drbg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  drbg_pkg::req_t   in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output drbg_pkg::rsp_t   out_data
);

    logic           q_valid, q_stall, busy;
    drbg_pkg::cmd_t q_data;

    drbg_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .q_valid(q_valid), .q_stall(q_stall), .q_data(q_data)
    );

    drbg_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_stall(q_stall), .q_data(q_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .busy(busy)
    );

`ifndef NO_ASSERTIONS
    a_last_half: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last == out_data.half))
        else $error("last and half disagree");
    a_vb_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.valid_bytes <= 4'd8))
        else $error("valid_bytes out of range");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !q_stall) |-> $past(rst_n))
        else $error("queue popped out of reset");
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("word shown while back end idle");
`endif

endmodule
